/* rtl/core/ntes_pkg.sv */
// Package for the nearest table entry search unit.
// Holds word widths, action and status codes, payload structs, the state type and abs_diff.
// Depends on nothing; every other file refers to it by scoped names.
`timescale 1ns / 1ps

package ntes_pkg;

  localparam int WORD_BITS  = 24;
  localparam int INDEX_BITS = 8;
  // The exact squared distance over four axes: a W-bit magnitude squares to 2W bits,
  // and four of them need two more bits.
  localparam int COST_BITS  = 2 * WORD_BITS + 2;

  localparam logic [1:0] ACT_CLEAR  = 2'd0;
  localparam logic [1:0] ACT_APPEND = 2'd1;
  localparam logic [1:0] ACT_QUERY  = 2'd2;

  localparam logic [1:0] ST_DONE  = 2'd0;
  localparam logic [1:0] ST_FULL  = 2'd1;
  localparam logic [1:0] ST_MATCH = 2'd2;
  localparam logic [1:0] ST_EMPTY = 2'd3;

  typedef logic signed [WORD_BITS-1:0] word_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t heading;
    word_t curvature;
  } key_t;

  typedef struct packed {
    word_t x;
    word_t y;
    word_t heading;
    word_t curvature;
    word_t param_0;
    word_t param_1;
    word_t param_2;
    word_t param_3;
    word_t arc_length;
  } entry_t;

  typedef struct packed {
    logic [1:0] action;
    word_t      key_x;
    word_t      key_y;
    word_t      key_heading;
    word_t      key_curvature;
    word_t      param_0;
    word_t      param_1;
    word_t      param_2;
    word_t      param_3;
    word_t      arc_length;
  } req_item_t;

  typedef struct packed {
    logic [1:0]            status;
    logic [INDEX_BITS-1:0] match_index;
    word_t                 match_x;
    word_t                 match_y;
    word_t                 match_heading;
    word_t                 match_curvature;
    word_t                 match_param_0;
    word_t                 match_param_1;
    word_t                 match_param_2;
    word_t                 match_param_3;
    word_t                 match_arc_length;
  } rsp_item_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_DRAIN,
    S_FINISH
  } fsm_state_t;

  // Magnitude of the difference of two signed words; it always fits WORD_BITS bits.
  function automatic logic [WORD_BITS-1:0] abs_diff(input word_t a, input word_t b);
    logic [WORD_BITS:0] d;
    logic [WORD_BITS:0] n;
    d = {a[WORD_BITS-1], a} - {b[WORD_BITS-1], b};
    n = d[WORD_BITS] ? (~d + 1'b1) : d;
    return n[WORD_BITS-1:0];
  endfunction

endpackage

/* rtl/core/nearest_table_entry_search_unit.sv */
// Top level of the nearest table entry search unit: control sequencer, best-match
// tracking and the response register. Instantiates ntes_table_mem and ntes_cost_pipe.
`timescale 1ns / 1ps

// The unit keeps a table of up to TABLE_DEPTH entries, each a 4-D state (x, y,
// heading, curvature) and five path parameters, in one synchronous memory. A
// request transaction clears the table, appends one entry, or queries with a 4-D
// state; each request yields exactly one response transaction. A query reads the
// stored entries in order, one per cycle through the memory's single read port,
// computes the exact squared Euclidean distance in a three-stage pipeline and keeps
// the closest entry, the later one winning on a tie; the winner is then read back
// for the response, and the next request can be taken once that response is loaded
// into the output register. Clear, append and a query on an empty table respond
// without a scan. The unit works on one request at a time, but takes the next
// request while a response still waits in the output register. Stored words that
// were never written after reset are never read, so the memory needs no clearing
// pass.

module nearest_table_entry_search_unit #(
  parameter int TABLE_DEPTH = 256
) (
  input  logic                clk,
  input  logic                rst,
  input  logic                req_valid,
  output logic                req_stall,
  input  ntes_pkg::req_item_t req_item,
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output ntes_pkg::rsp_item_t rsp_item
);

  localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

  ntes_pkg::fsm_state_t state, state_next;

  logic [CNT_W-1:0]               entry_count, count_next;
  logic [1:0]                     status_pend, status_next;
  ntes_pkg::key_t                 query;
  logic [IDX_W-1:0]               scan_addr;
  logic                           scan_rd;
  logic [CNT_W-1:0]               cmp_cnt;
  logic [IDX_W-1:0]               best_idx;
  logic [ntes_pkg::COST_BITS-1:0] best_cost;

  logic                           accept;
  logic                           mem_we;
  logic                           rd_en;
  logic [IDX_W-1:0]               rd_addr;
  ntes_pkg::entry_t               wr_data;
  ntes_pkg::entry_t               rd_data;
  ntes_pkg::key_t                 entry_key;
  logic                           pipe_busy;
  logic                           cost_valid;
  logic [ntes_pkg::COST_BITS-1:0] cost;
  logic                           pipe_empty;
  logic                           scan_last;
  logic                           rsp_load;
  ntes_pkg::rsp_item_t            rsp_next;

  assign accept     = req_valid && !req_stall;
  assign scan_last  = (CNT_W'(scan_addr) + CNT_W'(1)) == entry_count;
  // The best match is final once no read is in flight and no cost is left to compare.
  assign pipe_empty = !scan_rd && !pipe_busy && !cost_valid;

  assign wr_data = '{
    x:          req_item.key_x,
    y:          req_item.key_y,
    heading:    req_item.key_heading,
    curvature:  req_item.key_curvature,
    param_0:    req_item.param_0,
    param_1:    req_item.param_1,
    param_2:    req_item.param_2,
    param_3:    req_item.param_3,
    arc_length: req_item.arc_length
  };

  assign entry_key = '{
    x:         rd_data.x,
    y:         rd_data.y,
    heading:   rd_data.heading,
    curvature: rd_data.curvature
  };

  ntes_table_mem #(
    .DEPTH  (TABLE_DEPTH),
    .ADDR_W (IDX_W)
  ) u_table_mem (
    .clk     (clk),
    .we      (mem_we),
    .wr_addr (entry_count[IDX_W-1:0]),
    .wr_data (wr_data),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  ntes_cost_pipe u_cost_pipe (
    .clk        (clk),
    .rst        (rst),
    .valid      (scan_rd),
    .query      (query),
    .entry      (entry_key),
    .busy       (pipe_busy),
    .cost_valid (cost_valid),
    .cost       (cost)
  );

  // Next state and control. Appends write the memory in the accepting cycle, and a
  // query's reads start only in the following cycle, so no access to the same entry
  // can overlap within one request.
  always_comb begin
    state_next  = state;
    req_stall   = 1'b1;
    mem_we      = 1'b0;
    rd_en       = 1'b0;
    rd_addr     = scan_addr;
    rsp_load    = 1'b0;
    status_next = status_pend;
    count_next  = entry_count;
    case (state)
      ntes_pkg::S_IDLE: begin
        req_stall = 1'b0;
        if (req_valid) begin
          state_next  = ntes_pkg::S_FINISH;
          status_next = ntes_pkg::ST_DONE;
          case (req_item.action)
            ntes_pkg::ACT_CLEAR: begin
              count_next = '0;
            end
            ntes_pkg::ACT_APPEND: begin
              if (entry_count == CNT_W'(TABLE_DEPTH)) begin
                status_next = ntes_pkg::ST_FULL;
              end else begin
                mem_we     = 1'b1;
                count_next = entry_count + CNT_W'(1);
              end
            end
            ntes_pkg::ACT_QUERY: begin
              if (entry_count == '0) begin
                status_next = ntes_pkg::ST_EMPTY;
              end else begin
                status_next = ntes_pkg::ST_MATCH;
                state_next  = ntes_pkg::S_SCAN;
              end
            end
            default: begin
            end
          endcase
        end
      end
      ntes_pkg::S_SCAN: begin
        rd_en = 1'b1;
        if (scan_last) begin
          state_next = ntes_pkg::S_DRAIN;
        end
      end
      ntes_pkg::S_DRAIN: begin
        // Read the winning row back; its data arrives as the state enters FINISH.
        if (pipe_empty) begin
          rd_en      = 1'b1;
          rd_addr    = best_idx;
          state_next = ntes_pkg::S_FINISH;
        end
      end
      ntes_pkg::S_FINISH: begin
        if (!rsp_valid || !rsp_stall) begin
          rsp_load   = 1'b1;
          state_next = ntes_pkg::S_IDLE;
        end
      end
      default: begin
        state_next = ntes_pkg::S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= ntes_pkg::S_IDLE;
      entry_count <= '0;
      scan_rd     <= 1'b0;
      rsp_valid   <= 1'b0;
    end else begin
      state       <= state_next;
      entry_count <= count_next;
      scan_rd     <= (state == ntes_pkg::S_SCAN);
      if (rsp_load) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  // Query state, scan address and the running best match.
  always_ff @(posedge clk) begin
    status_pend <= status_next;
    if (accept) begin
      query.x         <= req_item.key_x;
      query.y         <= req_item.key_y;
      query.heading   <= req_item.key_heading;
      query.curvature <= req_item.key_curvature;
      scan_addr       <= '0;
      cmp_cnt         <= '0;
    end else begin
      if (state == ntes_pkg::S_SCAN) begin
        scan_addr <= scan_addr + IDX_W'(1);
      end
      if (cost_valid) begin
        // The first entry always takes the lead; later entries win ties.
        if (cmp_cnt == '0 || cost <= best_cost) begin
          best_cost <= cost;
          best_idx  <= cmp_cnt[IDX_W-1:0];
        end
        cmp_cnt <= cmp_cnt + CNT_W'(1);
      end
    end
  end

  // Response assembly: every field other than the status is zero unless matched.
  always_comb begin
    rsp_next        = '0;
    rsp_next.status = status_pend;
    if (status_pend == ntes_pkg::ST_MATCH) begin
      rsp_next.match_index      = ntes_pkg::INDEX_BITS'(best_idx);
      rsp_next.match_x          = rd_data.x;
      rsp_next.match_y          = rd_data.y;
      rsp_next.match_heading    = rd_data.heading;
      rsp_next.match_curvature  = rd_data.curvature;
      rsp_next.match_param_0    = rd_data.param_0;
      rsp_next.match_param_1    = rd_data.param_1;
      rsp_next.match_param_2    = rd_data.param_2;
      rsp_next.match_param_3    = rd_data.param_3;
      rsp_next.match_arc_length = rd_data.arc_length;
    end
  end

  always_ff @(posedge clk) begin
    if (rsp_load) begin
      rsp_item <= rsp_next;
    end
  end

  // Every stored entry has gone through the comparator before the winner is read.
  a_all_compared: assert property (@(posedge clk) disable iff (rst)
    (state == ntes_pkg::S_DRAIN) && pipe_empty |-> cmp_cnt == entry_count)
    else $error("scan finished before every entry was compared");

  // The scan never addresses a row beyond the filled part of the table.
  a_scan_in_range: assert property (@(posedge clk) disable iff (rst)
    state == ntes_pkg::S_SCAN |-> CNT_W'(scan_addr) < entry_count)
    else $error("scan address beyond filled entries");

  // A reported match always points at a filled entry.
  a_match_in_range: assert property (@(posedge clk) disable iff (rst)
    rsp_load && (status_pend == ntes_pkg::ST_MATCH) |-> CNT_W'(best_idx) < entry_count)
    else $error("match index beyond filled entries");

  // Costs only arrive while a query is scanning or draining.
  a_cost_in_query: assert property (@(posedge clk) disable iff (rst)
    cost_valid |-> (state == ntes_pkg::S_SCAN) || (state == ntes_pkg::S_DRAIN))
    else $error("distance result outside a query");

endmodule

/* rtl/core/ntes_table_mem.sv */
// Entry table storage: one synchronous memory, one write port and one read port.
// Read data is registered and holds until the next read. Uses ntes_pkg::entry_t.
`timescale 1ns / 1ps

module ntes_table_mem #(
  parameter int DEPTH  = 256,
  parameter int ADDR_W = 8
) (
  input  logic              clk,
  input  logic              we,
  input  logic [ADDR_W-1:0] wr_addr,
  input  ntes_pkg::entry_t  wr_data,
  input  logic              rd_en,
  input  logic [ADDR_W-1:0] rd_addr,
  output ntes_pkg::entry_t  rd_data
);

  ntes_pkg::entry_t mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

/* rtl/core/ntes_cost_pipe.sv */
// Three-stage squared-distance pipeline: magnitudes, squares, then the sum.
// One table row enters per cycle. Uses ntes_pkg widths, key_t and abs_diff.
`timescale 1ns / 1ps

module ntes_cost_pipe (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             valid,
  input  ntes_pkg::key_t                   query,
  input  ntes_pkg::key_t                   entry,
  output logic                             busy,
  output logic                             cost_valid,
  output logic [ntes_pkg::COST_BITS-1:0]   cost
);

  localparam int W = ntes_pkg::WORD_BITS;

  logic           mag_valid;
  logic           sq_valid;
  logic [W-1:0]   mag [4];
  logic [2*W-1:0] sq  [4];

  always_ff @(posedge clk) begin
    if (rst) begin
      mag_valid  <= 1'b0;
      sq_valid   <= 1'b0;
      cost_valid <= 1'b0;
    end else begin
      mag_valid  <= valid;
      sq_valid   <= mag_valid;
      cost_valid <= sq_valid;
    end
  end

  always_ff @(posedge clk) begin
    mag[0] <= ntes_pkg::abs_diff(query.x, entry.x);
    mag[1] <= ntes_pkg::abs_diff(query.y, entry.y);
    mag[2] <= ntes_pkg::abs_diff(query.heading, entry.heading);
    mag[3] <= ntes_pkg::abs_diff(query.curvature, entry.curvature);
    for (int k = 0; k < 4; k++) begin
      sq[k] <= mag[k] * mag[k];
    end
    cost <= {2'b00, sq[0]} + {2'b00, sq[1]} + {2'b00, sq[2]} + {2'b00, sq[3]};
  end

  assign busy = mag_valid | sq_valid;

endmodule

/* tb/tb_top.sv */
`timescale 1ns / 1ps
// Self-checking testbench for nearest_table_entry_search_unit: clear, append, query and
// unused-action transactions under random idling and output stalls, with every response
// checked against a local table copy. Depends on ntes_pkg and the unit itself.

module tb_top;

  localparam int         DEPTH        = 256;
  // The action field has one code that the unit must ignore.
  localparam logic [1:0] ACT_UNUSED   = 2'd3;
  localparam int         PHASE_ITEMS  = 350;
  localparam int         DRAIN_CYCLES = 16;
  localparam int         HOLD_CYCLES  = 400;
  // The slowest correct run is far below this: about 1400 transactions, each at most a
  // full-table query plus long stalls on both sides.
  localparam int         CYCLE_LIMIT  = 2_000_000;

  localparam ntes_pkg::word_t WORD_MAX = {1'b0, {(ntes_pkg::WORD_BITS-1){1'b1}}};
  localparam ntes_pkg::word_t WORD_MIN = {1'b1, {(ntes_pkg::WORD_BITS-1){1'b0}}};

  typedef logic [ntes_pkg::COST_BITS-1:0] cost_t;

  logic                clk       = 1'b0;
  logic                rst       = 1'b1;
  logic                req_valid = 1'b0;
  logic                req_stall;
  ntes_pkg::req_item_t req_item  = '0;
  logic                rsp_valid;
  logic                rsp_stall = 1'b0;
  ntes_pkg::rsp_item_t rsp_item;

  // Local copy of the search table, updated in the order transactions are accepted.
  ntes_pkg::entry_t    table_copy [DEPTH];
  int unsigned         table_fill;
  // Responses predicted for accepted requests and not yet seen at the output.
  ntes_pkg::rsp_item_t pending_rsp [$];

  int unsigned mismatch_count;
  int unsigned cycle_count;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned hold_cycles;

  nearest_table_entry_search_unit #(
    .TABLE_DEPTH(DEPTH)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .req_valid(req_valid),
    .req_stall(req_stall),
    .req_item (req_item),
    .rsp_valid(rsp_valid),
    .rsp_stall(rsp_stall),
    .rsp_item (rsp_item)
  );

  always #5 clk = ~clk;

  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
  end

  // Watchdog: a hung handshake or a lost response ends the run here.
  initial begin
    wait (cycle_count >= CYCLE_LIMIT);
    $display("nearest_table_entry_search_unit test failed");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Prediction
  // ---------------------------------------------------------------------------

  // Exact squared Euclidean distance over the four state axes. Each difference fits
  // 25 bits, so every square and the sum of four fit easily in 64 bits.
  function automatic cost_t squared_distance(input ntes_pkg::key_t k,
                                             input ntes_pkg::entry_t e);
    longint dx, dy, dh, dc;
    dx = longint'($signed(k.x)) - longint'($signed(e.x));
    dy = longint'($signed(k.y)) - longint'($signed(e.y));
    dh = longint'($signed(k.heading)) - longint'($signed(e.heading));
    dc = longint'($signed(k.curvature)) - longint'($signed(e.curvature));
    return cost_t'(dx * dx + dy * dy + dh * dh + dc * dc);
  endfunction

  // Applies one accepted request to the table copy and returns the response that the
  // unit owes for it. Every field but status stays zero unless an entry is selected.
  function automatic ntes_pkg::rsp_item_t response_for(input ntes_pkg::req_item_t it);
    ntes_pkg::rsp_item_t r;
    ntes_pkg::key_t      k;
    ntes_pkg::entry_t    e;
    cost_t               c;
    cost_t               best_cost;
    int unsigned         best;
    r        = '0;
    r.status = ntes_pkg::ST_DONE;
    case (it.action)
      ntes_pkg::ACT_CLEAR: begin
        // Only the count goes; the stored words stay but can no longer be selected.
        table_fill = 0;
      end
      ntes_pkg::ACT_APPEND: begin
        if (table_fill >= DEPTH) begin
          r.status = ntes_pkg::ST_FULL;
        end else begin
          table_copy[table_fill] = '{x: it.key_x, y: it.key_y, heading: it.key_heading,
                                     curvature: it.key_curvature, param_0: it.param_0,
                                     param_1: it.param_1, param_2: it.param_2,
                                     param_3: it.param_3, arc_length: it.arc_length};
          table_fill++;
        end
      end
      ntes_pkg::ACT_QUERY: begin
        if (table_fill == 0) begin
          r.status = ntes_pkg::ST_EMPTY;
        end else begin
          k         = '{x: it.key_x, y: it.key_y, heading: it.key_heading,
                        curvature: it.key_curvature};
          best      = 0;
          best_cost = '0;
          // The comparison is "less or equal", so the later entry wins on a tie.
          for (int unsigned i = 0; i < table_fill; i++) begin
            c = squared_distance(k, table_copy[i]);
            if (i == 0 || c <= best_cost) begin
              best_cost = c;
              best      = i;
            end
          end
          e                  = table_copy[best];
          r.status           = ntes_pkg::ST_MATCH;
          r.match_index      = ntes_pkg::INDEX_BITS'(best);
          r.match_x          = e.x;
          r.match_y          = e.y;
          r.match_heading    = e.heading;
          r.match_curvature  = e.curvature;
          r.match_param_0    = e.param_0;
          r.match_param_1    = e.param_1;
          r.match_param_2    = e.param_2;
          r.match_param_3    = e.param_3;
          r.match_arc_length = e.arc_length;
        end
      end
      default: begin
        // The unused action leaves the table as it is and still answers with done.
      end
    endcase
    return r;
  endfunction

  // ---------------------------------------------------------------------------
  // Checking
  // ---------------------------------------------------------------------------

  task automatic report_mismatch(input string what);
    $display("[%0t] mismatch: %s", $realtime, what);
    mismatch_count++;
  endtask

  task automatic check_field(input string name,
                             input logic [ntes_pkg::WORD_BITS-1:0] got,
                             input logic [ntes_pkg::WORD_BITS-1:0] want);
    if (got !== want) begin
      report_mismatch($sformatf("%s got %h, predicted %h", name, got, want));
    end
  endtask

  // Each response transaction is matched against the oldest outstanding prediction.
  always @(posedge clk) begin : check_responses
    ntes_pkg::rsp_item_t want;
    if (!rst && rsp_valid && !rsp_stall) begin
      if (pending_rsp.size() == 0) begin
        report_mismatch("response transaction with no request outstanding");
      end else begin
        want = pending_rsp.pop_front();
        check_field("status", ntes_pkg::WORD_BITS'(rsp_item.status),
                    ntes_pkg::WORD_BITS'(want.status));
        check_field("match_index", ntes_pkg::WORD_BITS'(rsp_item.match_index),
                    ntes_pkg::WORD_BITS'(want.match_index));
        check_field("match_x", rsp_item.match_x, want.match_x);
        check_field("match_y", rsp_item.match_y, want.match_y);
        check_field("match_heading", rsp_item.match_heading, want.match_heading);
        check_field("match_curvature", rsp_item.match_curvature, want.match_curvature);
        check_field("match_param_0", rsp_item.match_param_0, want.match_param_0);
        check_field("match_param_1", rsp_item.match_param_1, want.match_param_1);
        check_field("match_param_2", rsp_item.match_param_2, want.match_param_2);
        check_field("match_param_3", rsp_item.match_param_3, want.match_param_3);
        check_field("match_arc_length", rsp_item.match_arc_length, want.match_arc_length);
      end
    end
  end

  // Receiver side. A pending hold-off keeps the output stalled for a counted stretch;
  // otherwise the stall is drawn at random with the current probability.
  always @(posedge clk) begin
    if (hold_cycles != 0) begin
      rsp_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      rsp_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus helpers
  // ---------------------------------------------------------------------------

  // Random word with the extremes and small values over-weighted.
  function automatic ntes_pkg::word_t random_word();
    case ($urandom_range(7))
      0:       return WORD_MAX;
      1:       return WORD_MIN;
      2:       return '0;
      3:       return ntes_pkg::word_t'(int'($urandom_range(512)) - 256);
      default: return ntes_pkg::word_t'($urandom);
    endcase
  endfunction

  function automatic ntes_pkg::word_t jitter();
    return ntes_pkg::word_t'(int'($urandom_range(64)) - 32);
  endfunction

  function automatic ntes_pkg::req_item_t make_item(input logic [1:0] action);
    ntes_pkg::req_item_t it;
    it.action        = action;
    it.key_x         = random_word();
    it.key_y         = random_word();
    it.key_heading   = random_word();
    it.key_curvature = random_word();
    it.param_0       = random_word();
    it.param_1       = random_word();
    it.param_2       = random_word();
    it.param_3       = random_word();
    it.arc_length    = random_word();
    return it;
  endfunction

  function automatic ntes_pkg::req_item_t keyed_item(input logic [1:0] action,
                                                     input ntes_pkg::word_t x,
                                                     input ntes_pkg::word_t y,
                                                     input ntes_pkg::word_t h,
                                                     input ntes_pkg::word_t c);
    ntes_pkg::req_item_t it;
    it               = make_item(action);
    it.key_x         = x;
    it.key_y         = y;
    it.key_heading   = h;
    it.key_curvature = c;
    return it;
  endfunction

  // A query close to a stored entry, so that the winner is not always decided by the
  // extremes. Wrapping at the word limits is harmless.
  function automatic ntes_pkg::req_item_t near_query();
    ntes_pkg::req_item_t it;
    ntes_pkg::entry_t    e;
    it = make_item(ntes_pkg::ACT_QUERY);
    if (table_fill != 0) begin
      e                = table_copy[$urandom_range(table_fill - 1)];
      it.key_x         = e.x + jitter();
      it.key_y         = e.y + jitter();
      it.key_heading   = e.heading + jitter();
      it.key_curvature = e.curvature + jitter();
    end
    return it;
  endfunction

  // Offers one request transaction and returns once it is accepted. Valid stays high
  // into the next call unless an idle gap is drawn, so it is never lowered and raised
  // within one time step.
  task automatic send_item(input ntes_pkg::req_item_t it);
    if (send_idle_pct != 0 && $urandom_range(99) < send_idle_pct) begin
      req_valid <= 1'b0;
      do begin
        @(posedge clk);
      end while ($urandom_range(99) < send_idle_pct);
    end
    req_valid <= 1'b1;
    req_item  <= it;
    @(posedge clk);
    while (req_stall) begin
      @(posedge clk);
    end
    pending_rsp.insert(pending_rsp.size(), response_for(it));
  endtask

  // Sender pause: nothing is offered until every predicted response has come back.
  task automatic wait_drained();
    req_valid <= 1'b0;
    @(posedge clk);
    while (pending_rsp.size() != 0) begin
      @(posedge clk);
    end
    @(posedge clk);
  endtask

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------

  // Right after reset the table is empty: a query reports empty, and the unused action
  // and a clear simply answer done.
  task automatic test_empty_table();
    send_item(make_item(ntes_pkg::ACT_QUERY));
    send_item(make_item(ACT_UNUSED));
    send_item(make_item(ntes_pkg::ACT_CLEAR));
  endtask

  // Entries at the extremes of the signed range; the distances here reach the widest
  // values the cost path can see.
  task automatic test_extremes();
    ntes_pkg::req_item_t it;
    it = keyed_item(ntes_pkg::ACT_APPEND, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX);
    it.param_0    = WORD_MAX;
    it.param_1    = WORD_MAX;
    it.param_2    = WORD_MAX;
    it.param_3    = WORD_MAX;
    it.arc_length = WORD_MAX;
    send_item(it);
    it = keyed_item(ntes_pkg::ACT_APPEND, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN);
    it.param_0    = WORD_MIN;
    it.param_1    = WORD_MIN;
    it.param_2    = WORD_MIN;
    it.param_3    = WORD_MIN;
    it.arc_length = WORD_MIN;
    send_item(it);
    send_item(keyed_item(ntes_pkg::ACT_APPEND, '0, '0, '0, '0));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, WORD_MIN, WORD_MIN, WORD_MIN, WORD_MIN));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, WORD_MAX, WORD_MAX, WORD_MAX, WORD_MAX));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, WORD_MAX, WORD_MIN, WORD_MAX, WORD_MIN));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, WORD_MIN, WORD_MAX, WORD_MIN, WORD_MAX));
  endtask

  // Equal distances must select the later entry. Also checks that the unused action
  // leaves the table alone and that a clear hides the stale words.
  task automatic test_ties();
    send_item(make_item(ntes_pkg::ACT_CLEAR));
    send_item(keyed_item(ntes_pkg::ACT_APPEND, 24'sd4096, '0, '0, '0));
    send_item(keyed_item(ntes_pkg::ACT_APPEND, -24'sd4096, '0, '0, '0));
    send_item(keyed_item(ntes_pkg::ACT_APPEND, 24'sd4096, '0, '0, '0));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, '0, '0, '0, '0));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, 24'sd4096, '0, '0, '0));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, -24'sd4096, '0, '0, '0));
    send_item(make_item(ACT_UNUSED));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, -24'sd4000, '0, '0, '0));
    send_item(make_item(ntes_pkg::ACT_CLEAR));
    send_item(make_item(ntes_pkg::ACT_QUERY));
    send_item(keyed_item(ntes_pkg::ACT_APPEND, 24'sd7, 24'sd7, 24'sd7, 24'sd7));
    send_item(keyed_item(ntes_pkg::ACT_QUERY, 24'sd4096, '0, '0, '0));
  endtask

  // Fill every table position, then show that a further append is dropped and that a
  // query scans the whole table, including the last position.
  task automatic test_table_full();
    send_item(make_item(ntes_pkg::ACT_CLEAR));
    repeat (DEPTH) send_item(make_item(ntes_pkg::ACT_APPEND));
    send_item(make_item(ntes_pkg::ACT_APPEND));
    send_item(make_item(ntes_pkg::ACT_QUERY));
    send_item(near_query());
    send_item(keyed_item(ntes_pkg::ACT_QUERY, table_copy[DEPTH-1].x, table_copy[DEPTH-1].y,
                         table_copy[DEPTH-1].heading, table_copy[DEPTH-1].curvature));
    send_item(make_item(ACT_UNUSED));
    send_item(make_item(ntes_pkg::ACT_APPEND));
    send_item(make_item(ntes_pkg::ACT_CLEAR));
    send_item(make_item(ntes_pkg::ACT_QUERY));
  endtask

  // Mostly well-formed sequences (clear, a few appends, queries near stored entries),
  // with some loose transactions of any action mixed in. Table sizes are mostly small;
  // now and then one is filled far or completely.
  task automatic test_random_traffic(input int unsigned items, input int unsigned idle_pct,
                                     input int unsigned stall_pct);
    int unsigned         sent;
    int unsigned         fill_size;
    int unsigned         queries;
    int unsigned         pick;
    ntes_pkg::req_item_t it;
    send_idle_pct  = idle_pct;
    recv_stall_pct = stall_pct;
    sent           = 0;
    while (sent < items) begin
      if ($urandom_range(99) < 80) begin
        pick = $urandom_range(99);
        if (pick < 85) begin
          fill_size = $urandom_range(1, 6);
        end else if (pick < 98) begin
          fill_size = $urandom_range(7, 32);
        end else begin
          fill_size = $urandom_range(64, DEPTH);
        end
        queries = $urandom_range(1, 6);
        send_item(make_item(ntes_pkg::ACT_CLEAR));
        repeat (fill_size) send_item(make_item(ntes_pkg::ACT_APPEND));
        repeat (queries) begin
          if ($urandom_range(3) == 0) begin
            send_item(make_item(ntes_pkg::ACT_QUERY));
          end else begin
            send_item(near_query());
          end
        end
        sent += 1 + fill_size + queries;
      end else begin
        it = make_item(2'($urandom_range(3)));
        send_item(it);
        if (it.action != ACT_UNUSED) begin
          sent++;
        end
      end
    end
  endtask

  // The receiver holds off for a long stretch while requests keep coming, so the unit
  // runs out of room and stalls its input; afterwards the sender waits for a full drain.
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles   <= HOLD_CYCLES;
    send_item(make_item(ntes_pkg::ACT_CLEAR));
    repeat (8) send_item(make_item(ntes_pkg::ACT_APPEND));
    repeat (10) send_item(near_query());
    wait_drained();
    repeat (4) send_item(near_query());
    send_item(make_item(ntes_pkg::ACT_APPEND));
    send_item(make_item(ntes_pkg::ACT_QUERY));
  endtask

  // ---------------------------------------------------------------------------
  // Sequence of the run
  // ---------------------------------------------------------------------------

  initial begin
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    hold_cycles    = 0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    test_empty_table();
    test_extremes();
    test_ties();
    test_table_full();
    // Busy sender with a mostly stalled receiver, then the reverse, then full speed.
    test_random_traffic(PHASE_ITEMS, 11, 74);
    test_random_traffic(PHASE_ITEMS, 74, 11);
    test_random_traffic(PHASE_ITEMS, 0, 0);
    test_backpressure();

    req_valid <= 1'b0;
    while (pending_rsp.size() != 0) begin
      @(posedge clk);
    end
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (mismatch_count == 0) begin
      $display("nearest_table_entry_search_unit test passed");
    end else begin
      $display("nearest_table_entry_search_unit test failed");
    end
    $finish;
  end

endmodule

/* nearest_table_entry_search_unit.f */
rtl/core/ntes_pkg.sv
rtl/core/ntes_table_mem.sv
rtl/core/ntes_cost_pipe.sv
rtl/core/nearest_table_entry_search_unit.sv
tb/tb_top.sv
